FILE: rtl/arbr_pkg.sv
package arbr_pkg;

   // window length in bars and price width
   localparam int WINDOW     = 26;
   localparam int PRICE_BITS = 32;

   // result format: ratio times 100, 8 fraction bits, 32-bit saturating
   localparam int OUT_BITS   = 32;
   localparam int FRAC_BITS  = 8;
   localparam int SCALE      = 100;
   localparam int SCALE_BITS = $clog2(SCALE + 1);

   localparam int PTR_BITS   = $clog2(WINDOW);
   localparam int FILL_BITS  = $clog2(WINDOW + 1);
   localparam int SUM_BITS   = PRICE_BITS + $clog2(WINDOW);
   localparam int PROD_BITS  = SUM_BITS + SCALE_BITS;
   localparam int DIV_STEPS  = PROD_BITS + FRAC_BITS;
   localparam int REM_BITS   = SUM_BITS + 1;
   localparam int STEP_BITS  = $clog2(DIV_STEPS);

   localparam int NUM_SUMS   = 4;
   localparam int SUM_HO     = 0;
   localparam int SUM_OL     = 1;
   localparam int SUM_UP     = 2;
   localparam int SUM_DN     = 3;

   typedef logic [PRICE_BITS-1:0] price_type;
   typedef logic [SUM_BITS-1:0]   sum_type;

   typedef struct packed {
      price_type ho;
      price_type ol;
      price_type up;
      price_type dn;
   } terms_type;

   typedef struct packed {
      logic capture;
      logic terms;
      logic accum;
      logic div_load;
      logic div_step;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

FILE: rtl/arbr_if.sv
interface arbr_req_if;
   logic        valid;
   logic        ready;
   logic        series_start;
   logic [31:0] price_open;
   logic [31:0] price_high;
   logic [31:0] price_low;
   logic [31:0] price_close;

   modport source (
      output valid, series_start, price_open, price_high, price_low, price_close,
      input  ready
   );
   modport sink (
      input  valid, series_start, price_open, price_high, price_low, price_close,
      output ready
   );
endinterface

interface arbr_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] ar_value;
   logic        ar_valid;
   logic [31:0] br_value;
   logic        br_valid;

   modport source (
      output valid, ar_value, ar_valid, br_value, br_valid,
      input  ready
   );
   modport sink (
      input  valid, ar_value, ar_valid, br_value, br_valid,
      output ready
   );
endinterface

FILE: rtl/arbr_div.sv
module arbr_div (
   input  logic                               clock,
   input  logic                               load,
   input  logic                               step,
   input  logic [arbr_pkg::SUM_BITS-1:0]      num,
   input  logic [arbr_pkg::SUM_BITS-1:0]      den,
   output logic [arbr_pkg::OUT_BITS-1:0]      value,
   output logic                               valid
);

   logic [arbr_pkg::DIV_STEPS-1:0] dvd_ff;
   logic [arbr_pkg::SUM_BITS-1:0]  den_ff;
   logic [arbr_pkg::SUM_BITS-1:0]  rem_ff;
   logic [arbr_pkg::OUT_BITS-1:0]  quo_ff;
   logic                           sat_ff;

   logic [arbr_pkg::PROD_BITS-1:0] prod;
   logic [arbr_pkg::REM_BITS-1:0]  trial;
   logic [arbr_pkg::REM_BITS-1:0]  den_ext;
   logic [arbr_pkg::REM_BITS-1:0]  diff;
   logic                           ge;

   assign prod    = arbr_pkg::PROD_BITS'(num) * arbr_pkg::PROD_BITS'(arbr_pkg::SCALE);
   assign trial   = {rem_ff, dvd_ff[arbr_pkg::DIV_STEPS-1]};
   assign den_ext = {1'b0, den_ff};
   assign ge      = (trial >= den_ext);
   assign diff    = trial - den_ext;

   // restoring division, one quotient bit per step
   always_ff @(posedge clock) begin
      if (load) begin
         dvd_ff <= {prod, {arbr_pkg::FRAC_BITS{1'b0}}};
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
         sat_ff <= 1'b0;
      end else if (step) begin
         dvd_ff <= {dvd_ff[arbr_pkg::DIV_STEPS-2:0], 1'b0};
         rem_ff <= ge ? diff[arbr_pkg::SUM_BITS-1:0] : trial[arbr_pkg::SUM_BITS-1:0];
         quo_ff <= {quo_ff[arbr_pkg::OUT_BITS-2:0], ge};
         sat_ff <= sat_ff | quo_ff[arbr_pkg::OUT_BITS-1];
      end
   end

   assign valid = |den_ff;
   assign value = !valid ? '0 : (sat_ff ? '1 : quo_ff);

endmodule

FILE: rtl/arbr_ctrl.sv
module arbr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  arbr_pkg::status_type status,
   output arbr_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_TERMS = 3'd1;
   localparam logic [2:0] ST_ACCUM = 3'd2;
   localparam logic [2:0] ST_LOAD  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_DONE  = 3'd5;

   logic [2:0]                     state_ff, state_in;
   logic [arbr_pkg::STEP_BITS-1:0] step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_TERMS;
            end
         end
         ST_TERMS: begin
            cmd.terms = 1'b1;
            state_in  = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == arbr_pkg::STEP_BITS'(arbr_pkg::DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

FILE: rtl/arbr_dp.sv
module arbr_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  arbr_pkg::cmd_type     cmd,
   output arbr_pkg::status_type  status,
   input  logic                  series_start,
   input  logic [31:0]           price_open,
   input  logic [31:0]           price_high,
   input  logic [31:0]           price_low,
   input  logic [31:0]           price_close,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [31:0]           ar_value,
   output logic                  ar_valid,
   output logic [31:0]           br_value,
   output logic                  br_valid
);

   // captured bar
   logic                 start_ff;
   arbr_pkg::price_type  open_ff, high_ff, low_ff, close_ff;

   // window state
   arbr_pkg::terms_type            ring_mem [arbr_pkg::WINDOW];
   arbr_pkg::terms_type            old_ff;
   arbr_pkg::terms_type            terms_ff;
   arbr_pkg::sum_type              sums_ff [arbr_pkg::NUM_SUMS];
   arbr_pkg::price_type            prev_ff;
   logic [arbr_pkg::FILL_BITS-1:0] fill_ff;
   logic [arbr_pkg::PTR_BITS-1:0]  ptr_ff;

   // output register
   logic                           rsp_valid_ff;
   logic [arbr_pkg::OUT_BITS-1:0]  ar_value_ff, br_value_ff;
   logic                           ar_valid_ff, br_valid_ff;

   logic [arbr_pkg::FILL_BITS-1:0] eff_fill;
   arbr_pkg::price_type            eff_prev;
   logic                           full;
   arbr_pkg::terms_type            new_terms;
   logic [arbr_pkg::OUT_BITS-1:0]  ar_q, br_q;
   logic                           ar_ok, br_ok;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         start_ff <= series_start;
         open_ff  <= price_open[arbr_pkg::PRICE_BITS-1:0];
         high_ff  <= price_high[arbr_pkg::PRICE_BITS-1:0];
         low_ff   <= price_low[arbr_pkg::PRICE_BITS-1:0];
         close_ff <= price_close[arbr_pkg::PRICE_BITS-1:0];
      end
   end

   // a new series starts with an empty window and no previous close
   assign eff_fill = start_ff ? '0 : fill_ff;
   assign eff_prev = start_ff ? '0 : prev_ff;
   assign full     = (eff_fill == arbr_pkg::FILL_BITS'(arbr_pkg::WINDOW));

   always_comb begin
      new_terms.ho = (high_ff > open_ff) ? high_ff - open_ff : '0;
      new_terms.ol = (open_ff > low_ff) ? open_ff - low_ff : '0;
      new_terms.up = '0;
      new_terms.dn = '0;
      if (eff_fill != '0) begin
         new_terms.up = (high_ff > eff_prev) ? high_ff - eff_prev : '0;
         new_terms.dn = (eff_prev > low_ff) ? eff_prev - low_ff : '0;
      end
   end

   // slot under the pointer, read ahead of the terms step
   always_ff @(posedge clock) begin
      old_ff <= ring_mem[ptr_ff];
      if (cmd.accum) begin
         ring_mem[ptr_ff] <= terms_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.terms) begin
         terms_ff <= new_terms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < arbr_pkg::NUM_SUMS; k++) begin
            sums_ff[k] <= '0;
         end
         prev_ff <= '0;
         fill_ff <= '0;
         ptr_ff  <= '0;
      end else if (cmd.terms) begin
         // drop the oldest bar when the window is full
         sums_ff[arbr_pkg::SUM_HO] <= (start_ff ? '0 : sums_ff[arbr_pkg::SUM_HO])
            - (full ? arbr_pkg::SUM_BITS'(old_ff.ho) : '0);
         sums_ff[arbr_pkg::SUM_OL] <= (start_ff ? '0 : sums_ff[arbr_pkg::SUM_OL])
            - (full ? arbr_pkg::SUM_BITS'(old_ff.ol) : '0);
         sums_ff[arbr_pkg::SUM_UP] <= (start_ff ? '0 : sums_ff[arbr_pkg::SUM_UP])
            - (full ? arbr_pkg::SUM_BITS'(old_ff.up) : '0);
         sums_ff[arbr_pkg::SUM_DN] <= (start_ff ? '0 : sums_ff[arbr_pkg::SUM_DN])
            - (full ? arbr_pkg::SUM_BITS'(old_ff.dn) : '0);
         if (start_ff) begin
            prev_ff <= '0;
            fill_ff <= '0;
            ptr_ff  <= '0;
         end
      end else if (cmd.accum) begin
         sums_ff[arbr_pkg::SUM_HO] <= sums_ff[arbr_pkg::SUM_HO]
            + arbr_pkg::SUM_BITS'(terms_ff.ho);
         sums_ff[arbr_pkg::SUM_OL] <= sums_ff[arbr_pkg::SUM_OL]
            + arbr_pkg::SUM_BITS'(terms_ff.ol);
         sums_ff[arbr_pkg::SUM_UP] <= sums_ff[arbr_pkg::SUM_UP]
            + arbr_pkg::SUM_BITS'(terms_ff.up);
         sums_ff[arbr_pkg::SUM_DN] <= sums_ff[arbr_pkg::SUM_DN]
            + arbr_pkg::SUM_BITS'(terms_ff.dn);
         prev_ff <= close_ff;
         if (fill_ff != arbr_pkg::FILL_BITS'(arbr_pkg::WINDOW)) begin
            fill_ff <= fill_ff + 1'b1;
         end
         if (ptr_ff == arbr_pkg::PTR_BITS'(arbr_pkg::WINDOW - 1)) begin
            ptr_ff <= '0;
         end else begin
            ptr_ff <= ptr_ff + 1'b1;
         end
      end
   end

   arbr_div u_ar_div (
      .clock (clock),
      .load  (cmd.div_load),
      .step  (cmd.div_step),
      .num   (sums_ff[arbr_pkg::SUM_HO]),
      .den   (sums_ff[arbr_pkg::SUM_OL]),
      .value (ar_q),
      .valid (ar_ok)
   );

   arbr_div u_br_div (
      .clock (clock),
      .load  (cmd.div_load),
      .step  (cmd.div_step),
      .num   (sums_ff[arbr_pkg::SUM_UP]),
      .den   (sums_ff[arbr_pkg::SUM_DN]),
      .value (br_q),
      .valid (br_ok)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         ar_value_ff <= ar_q;
         ar_valid_ff <= ar_ok;
         br_value_ff <= br_q;
         br_valid_ff <= br_ok;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign ar_value        = ar_value_ff;
   assign ar_valid        = ar_valid_ff;
   assign br_value        = br_value_ff;
   assign br_valid        = br_valid_ff;

endmodule

FILE: rtl/ar_br_sentiment_indicator_core.sv
// AR/BR sentiment indicator over a sliding window of the last 26 daily bars. Each
// transfer on req_chan carries one bar (open, high, low, close) and a series_start
// flag that empties the window first; each bar yields exactly one transfer on
// rsp_chan with AR = 100*sum(high-open)/sum(open-low) and
// BR = 100*sum(max(0,high-prev close))/sum(max(0,prev close-low)), both unsigned
// with 8 fraction bits, rounded toward zero and saturated at 0xFFFFFFFF; a valid
// bit is low (and the value zero) when its denominator sum is zero. One bar is
// processed at a time: req_chan is ready only while the block is idle, so a new
// bar is not taken until the last result has gone to the output register. The
// restoring dividers make one quotient bit per cycle over the 44-bit scaled
// numerator plus 8 fraction bits; AR and BR divide in parallel in two units.
// A finished result waits in an output register, so the next bar is accepted
// while it is still pending.
module ar_br_sentiment_indicator_core (
   input  logic       clock,
   input  logic       reset,
   arbr_req_if.sink   req_chan,
   arbr_rsp_if.source rsp_chan
);

   // controller to datapath commands and back
   arbr_pkg::cmd_type    cmd;
   arbr_pkg::status_type status;

   // sequencer: capture, terms, accumulate, divide, hand off
   arbr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window ring, running sums, dividers and output register
   arbr_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .series_start (req_chan.series_start),
      .price_open   (req_chan.price_open),
      .price_high   (req_chan.price_high),
      .price_low    (req_chan.price_low),
      .price_close  (req_chan.price_close),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .ar_value     (rsp_chan.ar_value),
      .ar_valid     (rsp_chan.ar_valid),
      .br_value     (rsp_chan.br_value),
      .br_valid     (rsp_chan.br_valid)
   );

endmodule

FILE: bench/arbr_ratio_checker.sv
`timescale 1ns / 1ps

module arbr_ratio_checker (
   input  logic clock,
   input  logic reset,
   arbr_req_if  req_mon,
   arbr_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   pending_results
);

   localparam int DEPTH = arbr_pkg::WINDOW;

   typedef struct packed {
      logic [31:0] ar_value;
      logic        ar_valid;
      logic [31:0] br_value;
      logic        br_valid;
   } ratios_type;

   // per-bar terms still inside the window
   logic [31:0] ho_ring [DEPTH];
   logic [31:0] ol_ring [DEPTH];
   logic [31:0] up_ring [DEPTH];
   logic [31:0] dn_ring [DEPTH];
   logic [63:0] ho_sum, ol_sum, up_sum, dn_sum;
   logic [31:0] last_close;
   int          bars_held;
   int          slot;
   int          results_seen;
   ratios_type  expected_ratios [$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
      results_seen    = 0;
   end

   // floor(num * 100 * 256 / den) clipped to 32 bits, valid bit on top
   function automatic logic [32:0] percent_q8(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      if (den == 64'd0) return 33'd0;
      quo = ((num * 64'd100) << 8) / den;
      return {1'b1, (quo > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0]};
   endfunction

   task automatic clear_window();
      ho_sum     = '0;
      ol_sum     = '0;
      up_sum     = '0;
      dn_sum     = '0;
      last_close = '0;
      bars_held  = 0;
      slot       = 0;
   endtask

   task automatic advance_window(input logic start, input logic [31:0] op, input logic [31:0] hi,
                                 input logic [31:0] lo, input logic [31:0] cl);
      logic [31:0] t_ho, t_ol, t_up, t_dn;
      logic [32:0] ar, br;
      ratios_type  want;
      if (start) clear_window();
      t_ho = (hi > op) ? hi - op : '0;
      t_ol = (op > lo) ? op - lo : '0;
      t_up = (bars_held != 0 && hi > last_close) ? hi - last_close : '0;
      t_dn = (bars_held != 0 && last_close > lo) ? last_close - lo : '0;
      if (bars_held == DEPTH) begin
         ho_sum = ho_sum - ho_ring[slot];
         ol_sum = ol_sum - ol_ring[slot];
         up_sum = up_sum - up_ring[slot];
         dn_sum = dn_sum - dn_ring[slot];
      end else begin
         bars_held++;
      end
      ho_ring[slot] = t_ho;
      ol_ring[slot] = t_ol;
      up_ring[slot] = t_up;
      dn_ring[slot] = t_dn;
      ho_sum = ho_sum + t_ho;
      ol_sum = ol_sum + t_ol;
      up_sum = up_sum + t_up;
      dn_sum = dn_sum + t_dn;
      slot = (slot == DEPTH - 1) ? 0 : slot + 1;
      last_close = cl;
      ar = percent_q8(ho_sum, ol_sum);
      br = percent_q8(up_sum, dn_sum);
      want.ar_value = ar[31:0];
      want.ar_valid = ar[32];
      want.br_value = br[31:0];
      want.br_valid = br[32];
      expected_ratios.push_back(want);
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t: result %0d: %s", $time, results_seen, msg);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : track
      ratios_type want;
      if (reset) begin
         clear_window();
         expected_ratios.delete();
      end else begin
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1)
            advance_window(req_mon.series_start, req_mon.price_open, req_mon.price_high,
                           req_mon.price_low, req_mon.price_close);
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (expected_ratios.size() == 0) begin
               report_mismatch("result transfer with no bar waiting for it");
            end else begin
               want = expected_ratios.pop_front();
               if (rsp_mon.ar_value !== want.ar_value)
                  report_mismatch($sformatf("ar_value %h, expected %h",
                                            rsp_mon.ar_value, want.ar_value));
               if (rsp_mon.ar_valid !== want.ar_valid)
                  report_mismatch($sformatf("ar_valid %b, expected %b",
                                            rsp_mon.ar_valid, want.ar_valid));
               if (rsp_mon.br_value !== want.br_value)
                  report_mismatch($sformatf("br_value %h, expected %h",
                                            rsp_mon.br_value, want.br_value));
               if (rsp_mon.br_valid !== want.br_valid)
                  report_mismatch($sformatf("br_valid %b, expected %b",
                                            rsp_mon.br_valid, want.br_valid));
            end
            results_seen++;
         end
      end
      pending_results = expected_ratios.size();
   end

endmodule

FILE: bench/ar_br_sentiment_indicator_core_test.sv
`timescale 1ns / 1ps

module ar_br_sentiment_indicator_core_test;

   localparam int          RANDOM_BARS  = 900;
   // watchdog limit, several times what the slowest run needs
   localparam int          CYCLE_LIMIT  = 400000;
   // a bit more than one bar's division time
   localparam int          DRAIN_CYCLES = 80;
   localparam logic [31:0] PX_MAX       = 32'hFFFF_FFFF;

   typedef struct packed {
      logic        series_start;
      logic [31:0] open_px;
      logic [31:0] high_px;
      logic [31:0] low_px;
      logic [31:0] close_px;
   } bar_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          mismatch_count;
   int          pending_results;
   int          cycle_count = 0;
   // while set, both sides run back to back with no idle cycles
   bit          calm = 1'b0;
   // price level that well-formed bars wander around
   logic [31:0] walk_price = 32'd1000;

   arbr_req_if req_chan ();
   arbr_rsp_if rsp_chan ();

   ar_br_sentiment_indicator_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   arbr_ratio_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog: a hung handshake or a missing result ends here
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ar_br_sentiment_indicator_core verification failed");
      $finish;
   end

   function automatic int idle_gap();
      return calm ? 0 : $urandom_range(0, 14);
   endfunction

   // zero, all ones or anything
   function automatic logic [31:0] rail_price();
      case ($urandom_range(0, 2))
         0:       return '0;
         1:       return PX_MAX;
         default: return $urandom();
      endcase
   endfunction

   // a price inside [lo, hi], often sitting on one of the ends
   function automatic logic [31:0] pick_between(input logic [31:0] lo, input logic [31:0] hi);
      case ($urandom_range(0, 5))
         0:       return lo;
         1:       return hi;
         default: return lo + $urandom_range(0, hi - lo);
      endcase
   endfunction

   function automatic bar_type random_bar(input logic start);
      bar_type     bar;
      logic [31:0] span, dip;
      int unsigned mode;
      mode = $urandom_range(0, 19);
      bar.series_start = start;
      if (mode < 2) begin
         // noise: unrelated prices, mostly malformed bars
         bar.open_px  = $urandom();
         bar.high_px  = $urandom();
         bar.low_px   = $urandom();
         bar.close_px = $urandom();
      end else if (mode < 3) begin
         // prices pinned at the rails
         bar.open_px  = rail_price();
         bar.high_px  = rail_price();
         bar.low_px   = rail_price();
         bar.close_px = rail_price();
      end else begin
         // well-formed bar low <= open, close <= high around the walk price,
         // range size spread over all magnitudes
         span = $urandom() >> $urandom_range(0, 31);
         dip  = $urandom_range(0, span);
         bar.low_px   = (walk_price > dip) ? walk_price - dip : '0;
         bar.high_px  = (PX_MAX - bar.low_px > span) ? bar.low_px + span : PX_MAX;
         bar.open_px  = pick_between(bar.low_px, bar.high_px);
         bar.close_px = pick_between(bar.low_px, bar.high_px);
      end
      walk_price = bar.close_px;
      return bar;
   endfunction

   // one bar transfer: optional idle gap, then hold valid until ready
   task automatic send_bar(input bar_type bar);
      int gap;
      gap = idle_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.series_start <= bar.series_start;
      req_chan.price_open   <= bar.open_px;
      req_chan.price_high   <= bar.high_px;
      req_chan.price_low    <= bar.low_px;
      req_chan.price_close  <= bar.close_px;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // result side: random stall before each transfer, ready kept high across
   // back-to-back results
   initial begin : collector
      int gap;
      rsp_chan.ready <= 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = idle_gap();
         if (gap != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (rsp_chan.valid !== 1'b1) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      logic start;
      req_chan.valid        <= 1'b0;
      req_chan.series_start <= 1'b0;
      req_chan.price_open   <= '0;
      req_chan.price_high   <= '0;
      req_chan.price_low    <= '0;
      req_chan.price_close  <= '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // first bar after reset opens a series without the flag: no br yet
      send_bar('{1'b0, 32'd100, 32'd150, 32'd50, 32'd120});
      send_bar('{1'b0, 32'd120, 32'd200, 32'd100, 32'd180});
      // malformed bar: high under open, low over open
      send_bar('{1'b0, 32'd500, 32'd100, 32'd900, 32'd0});
      // new series with open on the low: ar denominator stays zero
      send_bar('{1'b1, 32'd1000, 32'd2000, 32'd1000, 32'd1500});
      // up term present but down term zero: br invalid with a nonzero numerator
      send_bar('{1'b0, 32'd1500, 32'd1600, 32'd1500, 32'd1550});
      // huge high-open over a one-unit open-low: ar saturates
      send_bar('{1'b1, 32'd1, PX_MAX, 32'd0, 32'd0});
      send_bar('{1'b0, 32'd0, PX_MAX, 32'd0, PX_MAX});
      // close at the top then a bar down to zero: full-scale down pressure
      send_bar('{1'b0, PX_MAX, PX_MAX, 32'd0, 32'd0});
      send_bar('{1'b0, 32'd0, 32'd0, 32'd0, 32'd0});
      send_bar('{1'b0, PX_MAX, PX_MAX, PX_MAX, PX_MAX});
      // all-zero series: both ratios invalid
      send_bar('{1'b1, 32'd0, 32'd0, 32'd0, 32'd0});
      send_bar('{1'b1, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0000});
      send_bar('{1'b0, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hA5A5_A5A5});
      send_bar('{1'b0, 32'hA5A5_A5A5, 32'hFFFF_0000, 32'h0000_FFFF, 32'h5A5A_5A5A});

      // random bars: long series so the window fills and slides, the odd
      // short one, mostly well-formed with some noise mixed in
      walk_price = $urandom();
      for (int n = 0; n < RANDOM_BARS; n++) begin
         if ($urandom_range(0, 59) == 0) calm = !calm;
         start = ($urandom_range(0, 39) == 0);
         if (start) walk_price = $urandom() >> $urandom_range(0, 28);
         send_bar(random_bar(start));
      end
      req_chan.valid <= 1'b0;

      // every bar accepted: wait for the last results, then a quiet stretch
      // to catch anything extra
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("ar_br_sentiment_indicator_core verification clean");
      else
         $display("ar_br_sentiment_indicator_core verification failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/arbr_pkg.sv
rtl/arbr_if.sv
rtl/arbr_div.sv
rtl/arbr_ctrl.sv
rtl/arbr_dp.sv
rtl/ar_br_sentiment_indicator_core.sv
bench/arbr_ratio_checker.sv
bench/ar_br_sentiment_indicator_core_test.sv
